// ===== sv/assert_macros.svh =====
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define SIS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression that must never be true outside reset
`define SIS_NEVER(label, expr, msg) \
	`SIS_ASSERT(label, !(expr), msg)

`endif

// ===== sv/sis_pkg.sv =====
// types and constants for the stable insertion sorter
`timescale 1ns / 1ps
package sis_pkg;
	localparam int DEPTH_DEF = 64;

	typedef struct packed {
		logic signed [63:0] key;
		logic [15:0]        tag;
		logic               final_entry;
	} item_t;

	typedef struct packed {
		logic signed [63:0] sorted_key;
		logic [15:0]        sorted_tag;
		logic               end_of_run;
		logic               overflowed;
	} result_t;

	typedef struct packed {
		logic signed [63:0] key;
		logic [15:0]        tag;
	} entry_t;
endpackage

// ===== sv/sis_cmp.sv =====
// shared signed key comparator used for every insertion step
`timescale 1ns / 1ps
module sis_cmp (
	input  logic signed [63:0] stored_key,
	input  logic signed [63:0] new_key,
	output logic               stored_gt
);
	// strictly greater moves up, equal keys stay ahead
	assign stored_gt = (stored_key > new_key);
endmodule

// ===== sv/sis_store.sv =====
// entry memory: one write port, one registered read port
`timescale 1ns / 1ps
module sis_store #(
	parameter int DEPTH = sis_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  sis_pkg::entry_t          wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output sis_pkg::entry_t          rdata
);
	import sis_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/stable_insertion_sort_by_key.sv =====
// channel | dir | handshake               | payload
// item    | in  | item_valid, item_stall     | item (key, tag, final_entry)
// result  | out | result_valid, result_stall | result (sorted_key, sorted_tag,
//         |     |                            |   end_of_run, overflowed)
// an entry at an empty or full store is handled on acceptance, else it walks down
// past the stored keys greater than it in the shift state, one memory read per step
// a final entry then reads out the store in order, a load and a wait state per result, held by result_stall
// item_stall is high while an entry is shifted in and until the last result of a run is taken
// arst_n empties the store and clears the overflow flag, no clearing pass
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stable_insertion_sort_by_key #(
	parameter int DEPTH = sis_pkg::DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  sis_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output sis_pkg::result_t result
);
	import sis_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SHIFT = 3'd1;
	localparam logic [2:0] ST_PLACE = 3'd2;
	localparam logic [2:0] ST_EREAD = 3'd3;
	localparam logic [2:0] ST_ELOAD = 3'd4;
	localparam logic [2:0] ST_EWAIT = 3'd5;

	logic [2:0]    state_q;
	logic [CW-1:0] fill_q;
	logic          ovf_q;
	logic [AW-1:0] idx_q;
	entry_t        cur_q;
	logic          fin_q;
	result_t       res_q;
	logic          res_valid_q;

	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wdata;
	logic [AW-1:0] raddr;
	entry_t        rdata;
	logic          stored_gt;
	logic          accept;
	logic          full;
	logic [AW-1:0] last_idx;

	assign accept   = item_valid && !item_stall;
	assign full     = (fill_q == CW'(DEPTH));
	assign last_idx = AW'(fill_q - CW'(1));

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	sis_store #(.DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	sis_cmp u_cmp (
		.stored_key (rdata.key),
		.new_key    (cur_q.key),
		.stored_gt  (stored_gt)
	);

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = cur_q;
		raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !full) begin
					if (fill_q == '0) begin
						we          = 1'b1;
						wdata.key   = item.key;
						wdata.tag   = item.tag;
					end else begin
						raddr = last_idx;
					end
				end
			end
			ST_SHIFT: begin
				we = 1'b1;
				waddr = idx_q + AW'(1);
				if (stored_gt) begin
					wdata = rdata;
					raddr = idx_q - AW'(1);
				end
			end
			ST_PLACE: begin
				we = 1'b1;
			end
			ST_EREAD: begin
				raddr = '0;
			end
			ST_ELOAD: begin
				raddr = idx_q;
			end
			ST_EWAIT: begin
				raddr = idx_q + AW'(1);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (full) begin
							ovf_q   <= 1'b1;
							state_q <= item.final_entry ? ST_EREAD : ST_IDLE;
						end else if (fill_q == '0) begin
							fill_q  <= fill_q + CW'(1);
							state_q <= item.final_entry ? ST_EREAD : ST_IDLE;
						end else begin
							idx_q   <= last_idx;
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					if (stored_gt) begin
						if (idx_q == '0) begin
							state_q <= ST_PLACE;
						end else begin
							idx_q <= idx_q - AW'(1);
						end
					end else begin
						fill_q  <= fill_q + CW'(1);
						state_q <= fin_q ? ST_EREAD : ST_IDLE;
					end
				end
				ST_PLACE: begin
					fill_q  <= fill_q + CW'(1);
					state_q <= fin_q ? ST_EREAD : ST_IDLE;
				end
				ST_EREAD: begin
					idx_q   <= '0;
					state_q <= ST_ELOAD;
				end
				ST_ELOAD: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_EWAIT;
				end
				ST_EWAIT: begin
					if (!result_stall) begin
						res_valid_q <= 1'b0;
						if (idx_q == last_idx) begin
							fill_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= ST_ELOAD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q.key <= item.key;
			cur_q.tag <= item.tag;
			fin_q     <= item.final_entry;
		end
		if (state_q == ST_ELOAD) begin
			res_q.sorted_key <= rdata.key;
			res_q.sorted_tag <= rdata.tag;
			res_q.end_of_run <= (idx_q == last_idx);
			res_q.overflowed <= ovf_q;
		end
	end

	`SIS_NEVER(a_fill_bound, fill_q > CW'(DEPTH), "fill count above depth")
	`SIS_NEVER(a_accept_while_result, accept && res_valid_q, "item taken while result pending")
	`SIS_ASSERT(a_run_clears, res_valid_q && res_q.end_of_run && !result_stall |=> fill_q == '0 && !ovf_q, "store not emptied after run")
	`SIS_NEVER(a_emit_empty, state_q == ST_ELOAD && fill_q == '0, "emitting from empty store")
endmodule
